// ----- rtl/sorted_value_list_unit_defines.svh -----
// Assertion macros shared by the sorted value list checker.
`ifndef SORTED_VALUE_LIST_UNIT_DEFINES_SVH
`define SORTED_VALUE_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SVL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- rtl/svl_pkg.sv -----
// Package for the sorted value list: item types, codes and shared constants.
package svl_pkg;

  localparam int SVL_CAPACITY = 64;
  localparam int CNT_OUT_W    = 7;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [1:0] STATUS_DONE   = 2'd0;
  localparam logic [1:0] STATUS_ABSENT = 2'd1;
  localparam logic [1:0] STATUS_EMPTY  = 2'd2;
  localparam logic [1:0] STATUS_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [CNT_OUT_W-1:0] count_after;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture the input item, open the search window
    logic       srch_rd;   // read the middle of the search window
    logic       srch_upd;  // narrow the window from the read entry
    logic       sh_init;   // set the shift pointer
    logic       sh_wr;     // move one entry and step the shift pointer
    logic       wr_new;    // write the new value at its place, count up
    logic       cnt_dec;   // count down after a remove
    logic       cnt_clr;   // drop all entries
    logic       out_load;  // load the result register
    logic [1:0] res;       // status code of the result
  } svl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] func;
    logic       cnt_zero;
    logic       cnt_full;
    logic       srch_done;
    logic       found;
    logic       pos_at_end;
    logic       rem_tail;
    logic       rp_last;
  } svl_sts_t;

endpackage

// ----- rtl/svl_ctrl.sv -----
// Controller state machine of the sorted value list.
module svl_ctrl import svl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  svl_sts_t sts_i,
  output svl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SRCH_RD,
    ST_SRCH_UPD,
    ST_PLACE,
    ST_SH_RD,
    ST_SH_WR,
    ST_WR_NEW,
    ST_FINISH
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] res_q, res_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.res = res_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        case (sts_i.func)
          FUNC_INSERT: begin
            if (sts_i.cnt_full) begin
              res_d   = STATUS_FULL;
              state_d = ST_FINISH;
            end else begin
              state_d = ST_SRCH_RD;
            end
          end
          FUNC_CLEAR: begin
            res_d         = sts_i.cnt_zero ? STATUS_EMPTY : STATUS_DONE;
            cmd_o.cnt_clr = 1'b1;
            state_d       = ST_FINISH;
          end
          default: begin
            if (sts_i.cnt_zero) begin
              res_d   = STATUS_EMPTY;
              state_d = ST_FINISH;
            end else begin
              state_d = ST_SRCH_RD;
            end
          end
        endcase
      end
      ST_SRCH_RD: begin
        if (sts_i.srch_done) begin
          state_d = ST_PLACE;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d       = ST_SRCH_UPD;
        end
      end
      ST_SRCH_UPD: begin
        cmd_o.srch_upd = 1'b1;
        state_d        = ST_SRCH_RD;
      end
      ST_PLACE: begin
        if (sts_i.func == FUNC_INSERT) begin
          if (sts_i.pos_at_end) begin
            state_d = ST_WR_NEW;
          end else begin
            cmd_o.sh_init = 1'b1;
            state_d       = ST_SH_RD;
          end
        end else if (!sts_i.found) begin
          res_d   = STATUS_ABSENT;
          state_d = ST_FINISH;
        end else if (sts_i.func == FUNC_LOOKUP) begin
          res_d   = STATUS_DONE;
          state_d = ST_FINISH;
        end else if (sts_i.rem_tail) begin
          res_d         = STATUS_DONE;
          cmd_o.cnt_dec = 1'b1;
          state_d       = ST_FINISH;
        end else begin
          cmd_o.sh_init = 1'b1;
          state_d       = ST_SH_RD;
        end
      end
      ST_SH_RD: begin
        state_d = ST_SH_WR;
      end
      ST_SH_WR: begin
        cmd_o.sh_wr = 1'b1;
        if (!sts_i.rp_last) begin
          state_d = ST_SH_RD;
        end else if (sts_i.func == FUNC_INSERT) begin
          state_d = ST_WR_NEW;
        end else begin
          res_d         = STATUS_DONE;
          cmd_o.cnt_dec = 1'b1;
          state_d       = ST_FINISH;
        end
      end
      ST_WR_NEW: begin
        cmd_o.wr_new = 1'b1;
        res_d        = STATUS_DONE;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = (out_valid_q && out_stall_i) || cmd_o.out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_q       <= STATUS_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/svl_dpath.sv -----
// Datapath of the sorted value list: entry memory, search window, shift pointer, count.
module svl_dpath import svl_pkg::*; #(
  parameter int CAPACITY = SVL_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  svl_cmd_t  cmd_i,
  output svl_sts_t  sts_o,
  output out_item_t out_item_o
);

  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int ExtW = (CntW > CNT_OUT_W) ? CntW : CNT_OUT_W;

  logic signed [31:0] mem [CAPACITY];

  logic [1:0]         func_q;
  logic signed [31:0] value_q;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    lo_q, hi_q, rp_q;
  logic               eq_q;
  logic signed [31:0] rdata_q;
  out_item_t          out_q;

  logic [CntW:0]      win_sum;
  logic [CntW-1:0]    mid;
  logic [IdxW-1:0]    raddr, waddr;
  logic               wen;
  logic signed [31:0] wdata;
  logic               is_ins;
  logic [ExtW-1:0]    cnt_ext;

  assign is_ins  = (func_q == FUNC_INSERT);
  assign win_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = win_sum[CntW:1];
  assign raddr   = cmd_i.srch_rd ? mid[IdxW-1:0] : rp_q[IdxW-1:0];

  // Shifts move toward higher slots for insert and toward lower slots for remove.
  always_comb begin
    wen   = cmd_i.sh_wr || cmd_i.wr_new;
    wdata = cmd_i.wr_new ? value_q : rdata_q;
    if (cmd_i.wr_new) begin
      waddr = lo_q[IdxW-1:0];
    end else if (is_ins) begin
      waddr = IdxW'(rp_q + CntW'(1));
    end else begin
      waddr = IdxW'(rp_q - CntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_clr) begin
      count_d = '0;
    end else if (cmd_i.wr_new) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign cnt_ext = ExtW'(count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= in_item_i.func;
      value_q <= in_item_i.value;
      lo_q    <= '0;
      hi_q    <= count_q;
      eq_q    <= 1'b0;
    end
    if (cmd_i.srch_upd) begin
      if (rdata_q < value_q) begin
        lo_q <= mid + CntW'(1);
      end else begin
        hi_q <= mid;
        eq_q <= (rdata_q == value_q);
      end
    end
    if (cmd_i.sh_init) begin
      rp_q <= is_ins ? (count_q - CntW'(1)) : (lo_q + CntW'(1));
    end else if (cmd_i.sh_wr) begin
      rp_q <= is_ins ? (rp_q - CntW'(1)) : (rp_q + CntW'(1));
    end
    if (cmd_i.out_load) begin
      out_q.status      <= cmd_i.res;
      out_q.count_after <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  always_comb begin
    sts_o.func       = func_q;
    sts_o.cnt_zero   = (count_q == '0);
    sts_o.cnt_full   = (count_q == CntW'(CAPACITY));
    sts_o.srch_done  = (lo_q == hi_q);
    sts_o.found      = eq_q;
    sts_o.pos_at_end = (lo_q == count_q);
    sts_o.rem_tail   = (lo_q == count_q - CntW'(1));
    sts_o.rp_last    = is_ins ? (rp_q == lo_q) : (rp_q == count_q - CntW'(1));
  end

  assign out_item_o = out_q;

endmodule

// ----- rtl/sorted_value_list_unit.sv -----
// Top level of the sorted value list: a bounded table of signed values kept in order.
//
//   channel   direction   handshake              payload
//   in        into block  in_valid_i/in_stall_o  in_item_i  (func, value)
//   out       from block  out_valid_o/out_stall_i out_item_o (status, count_after)
//
// From its accepting edge a command passes through decode, binary search steps (at
// most log2(count)+1 steps, each a read and a narrowing of the window), the close of
// the search, a read and a write per entry moved by an insert or remove, a write of
// the value for an insert and the load of the result; then idle takes the next item.
// Reset clears the count and control state; only entries below the count are read.
// A new item is taken while a result is stalled; the next result waits until it leaves.
module sorted_value_list_unit import svl_pkg::*; #(
  parameter int CAPACITY = SVL_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // Command and status links between the state machine and the datapath.
  svl_cmd_t cmd;
  svl_sts_t sts;

  // The controller sequences each command: decode, binary search over the
  // stored entries, then a one-entry-at-a-time shift for insert and remove.
  svl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the entries in ascending order in a memory with one
  // write and one registered read per cycle, plus the count and the result.
  svl_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

endmodule

// ----- rtl/svl_checker.sv -----
// Port-level checker for the sorted value list, bound to the top level.
`include "sorted_value_list_unit_defines.svh"

module svl_checker import svl_pkg::*; #(
  parameter int CAPACITY = SVL_CAPACITY
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  localparam logic [CNT_OUT_W-1:0] CapOut = CNT_OUT_W'(CAPACITY);

  logic out_held;
  logic rep_full;
  logic rep_empty;

  assign out_held  = out_valid_o && out_stall_i;
  assign rep_full  = out_valid_o && (out_item_o.status == STATUS_FULL);
  assign rep_empty = out_valid_o && (out_item_o.status == STATUS_EMPTY);

  // An accepted item keeps the block busy for at least the next cycle.
  `SVL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A stalled result stays put.
  `SVL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_item_o))

  // A refused insert reports a table filled to capacity.
  `SVL_ASSERT_IMPL(a_full_count, clk_i, rst_ni, rep_full, out_item_o.count_after == CapOut)

  // An empty-table report always comes with an entry count of zero.
  `SVL_ASSERT_IMPL(a_empty_count, clk_i, rst_ni, rep_empty, out_item_o.count_after == '0)

endmodule

bind sorted_value_list_unit svl_checker #(.CAPACITY(CAPACITY)) u_svl_checker (.*);
